// ===== design/pts_pkg.sv =====
// Package for the priority thread scheduler: sizes, request and status codes,
// slot states and the sequencer state type. No dependencies.
package pts_pkg;
	localparam int MAX_THREADS_DEF = 16;
	localparam int PRIO_BITS_DEF = 8;
	localparam int TICK_BITS_DEF = 32;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_SCHEDULE = 2'd1,
		REQ_SLEEP = 2'd2,
		REQ_TICK = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_FULL = 2'd1,
		STAT_NO_READY = 2'd2,
		STAT_NOT_RUNNING = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		SL_IDLE = 2'd0,
		SL_READY = 2'd1,
		SL_RUNNING = 2'd2,
		SL_BLOCKED = 2'd3
	} slot_state_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_INS_FIND,
		ST_INS_SHIFT,
		ST_POP,
		ST_TICK,
		ST_DONE
	} seq_state_t;
endpackage

// ===== design/priority_thread_scheduler.sv =====
// Top level of the priority thread scheduler: slot tables, ready order and a
// sequencer that walks them one entry a cycle. Depends on pts_pkg.
//
// channel | dir | handshake           | payload
// s_axis  | in  | s_axis_tvalid/tready| tdata: req_type, priority_req, sleep_ticks
// m_axis  | out | m_axis_tvalid/tready| tdata: status .. woken_count
//
// Create: when a slot is free, a compare walk, a shift walk, then the finish step.
// Schedule: an insertion walk when the running thread is not blocked, then the pop shift walk.
// Tick: one slot per cycle, N slots, each wake may add an insertion walk.
// Sleep: no walk, straight to the finish step. N is MAX_THREADS; a single compare/shift unit serves every walk.
// Reset restores slot 0 as the ready idle thread at once. Input is not taken
// while a word is in work or the result word waits on the output.
module priority_thread_scheduler #(
	parameter int MAX_THREADS = pts_pkg::MAX_THREADS_DEF,
	parameter int PRIO_BITS = pts_pkg::PRIO_BITS_DEF,
	parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [1:0] req_type, [9:2] priority_req, [41:10] sleep_ticks, zero fill
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [1:0] status, [5:2] new_thread, [9:6] prev_thread, [13:10] next_thread,
	// [14] switch_now, [19:15] woken_count, zero fill
	output logic [23:0] m_axis_tdata
);
	localparam int SW = $clog2(MAX_THREADS);
	localparam int LW = $clog2(MAX_THREADS + 1);
	localparam int PW = (PRIO_BITS < 8) ? PRIO_BITS : 8;
	localparam int TW = (TICK_BITS < 32) ? TICK_BITS : 32;

	pts_pkg::seq_state_t state_q, state_d;

	logic [PRIO_BITS-1:0] prio_q [MAX_THREADS];
	pts_pkg::slot_state_t sst_q [MAX_THREADS];
	logic [TICK_BITS-1:0] wake_q [MAX_THREADS];
	logic [SW-1:0] order_q [MAX_THREADS];
	logic [LW-1:0] len_q;
	logic [SW-1:0] run_q;
	logic run_vld_q;
	logic [LW-1:0] free_q;

	// Per-request working registers.
	pts_pkg::req_t req_q;
	logic [SW-1:0] ins_slot_q;
	logic [LW-1:0] pos_q;
	logic [LW-1:0] idx_q;
	logic [SW-1:0] tick_i_q;
	logic [1:0] stat_q;
	logic [3:0] new_q, prev_q, next_q;
	logic sw_q;
	logic [4:0] woken_q;
	logic out_vld_q;

	logic [PRIO_BITS-1:0] in_prio;
	logic [TICK_BITS-1:0] in_ticks;
	logic [TICK_BITS-1:0] wdec;
	logic tick_last;

	assign in_prio = PRIO_BITS'(s_axis_tdata[2 +: PW]);
	assign in_ticks = TICK_BITS'(s_axis_tdata[10 +: TW]);
	assign s_axis_tready = (state_q == pts_pkg::ST_WAIT) && !out_vld_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {4'd0, woken_q, sw_q, next_q, prev_q, new_q, stat_q};
	assign wdec = wake_q[tick_i_q] - TICK_BITS'(1);
	assign tick_last = (tick_i_q == SW'(MAX_THREADS - 1));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state from the current step of the walk.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pts_pkg::ST_WAIT: begin
				if (s_axis_tvalid && s_axis_tready) begin
					case (pts_pkg::req_t'(s_axis_tdata[1:0]))
						pts_pkg::REQ_CREATE: begin
							state_d = (free_q >= LW'(MAX_THREADS)) ? pts_pkg::ST_DONE
								: pts_pkg::ST_INS_FIND;
						end
						pts_pkg::REQ_SCHEDULE: begin
							if (run_vld_q && sst_q[run_q] != pts_pkg::SL_BLOCKED) begin
								state_d = pts_pkg::ST_INS_FIND;
							end else begin
								state_d = pts_pkg::ST_POP;
							end
						end
						pts_pkg::REQ_TICK: state_d = pts_pkg::ST_TICK;
						default: state_d = pts_pkg::ST_DONE;
					endcase
				end
			end
			pts_pkg::ST_INS_FIND: begin
				if (len_q >= LW'(MAX_THREADS)) begin
					state_d = (req_q == pts_pkg::REQ_SCHEDULE) ? pts_pkg::ST_POP
						: (req_q == pts_pkg::REQ_TICK && !tick_last) ? pts_pkg::ST_TICK
						: pts_pkg::ST_DONE;
				end else if (!(pos_q < len_q && prio_q[order_q[pos_q[SW-1:0]]]
						> prio_q[ins_slot_q])) begin
					state_d = pts_pkg::ST_INS_SHIFT;
				end
			end
			pts_pkg::ST_INS_SHIFT: begin
				if (idx_q <= pos_q) begin
					state_d = (req_q == pts_pkg::REQ_SCHEDULE) ? pts_pkg::ST_POP
						: (req_q == pts_pkg::REQ_TICK && !tick_last) ? pts_pkg::ST_TICK
						: pts_pkg::ST_DONE;
				end
			end
			pts_pkg::ST_POP: begin
				if (len_q == '0 || idx_q + LW'(1) >= len_q) begin
					state_d = pts_pkg::ST_DONE;
				end
			end
			pts_pkg::ST_TICK: begin
				if (wake_q[tick_i_q] != '0 && wdec == '0
						&& sst_q[tick_i_q] == pts_pkg::SL_BLOCKED
						&& !(run_vld_q && run_q == tick_i_q)) begin
					state_d = pts_pkg::ST_INS_FIND;
				end else if (tick_last) begin
					state_d = pts_pkg::ST_DONE;
				end
			end
			pts_pkg::ST_DONE: state_d = pts_pkg::ST_WAIT;
			default: state_d = pts_pkg::ST_WAIT;
		endcase
	end

	// Control registers and tables, one step of work per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				prio_q[i] <= '0;
				sst_q[i] <= (i == 0) ? pts_pkg::SL_READY : pts_pkg::SL_IDLE;
				wake_q[i] <= '0;
				order_q[i] <= '0;
			end
			len_q <= LW'(1);
			run_q <= '0;
			run_vld_q <= 1'b0;
			free_q <= LW'(1);
			out_vld_q <= 1'b0;
			req_q <= pts_pkg::REQ_CREATE;
			ins_slot_q <= '0;
			pos_q <= '0;
			idx_q <= '0;
			tick_i_q <= '0;
			stat_q <= pts_pkg::STAT_OK;
			new_q <= '0;
			prev_q <= '0;
			next_q <= '0;
			sw_q <= 1'b0;
			woken_q <= '0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				pts_pkg::ST_WAIT: begin
					if (s_axis_tvalid && s_axis_tready) begin
						req_q <= pts_pkg::req_t'(s_axis_tdata[1:0]);
						stat_q <= pts_pkg::STAT_OK;
						new_q <= '0;
						prev_q <= '0;
						next_q <= '0;
						sw_q <= 1'b0;
						woken_q <= '0;
						pos_q <= '0;
						idx_q <= '0;
						tick_i_q <= '0;
						case (pts_pkg::req_t'(s_axis_tdata[1:0]))
							pts_pkg::REQ_CREATE: begin
								if (free_q >= LW'(MAX_THREADS)) begin
									stat_q <= pts_pkg::STAT_FULL;
								end else begin
									prio_q[free_q[SW-1:0]] <= in_prio;
									ins_slot_q <= free_q[SW-1:0];
									new_q <= 4'(free_q);
									free_q <= free_q + LW'(1);
								end
							end
							pts_pkg::REQ_SCHEDULE: begin
								if (run_vld_q) begin
									prev_q <= 4'(run_q);
									ins_slot_q <= run_q;
									run_vld_q <= 1'b0;
								end
							end
							pts_pkg::REQ_SLEEP: begin
								if (!run_vld_q) begin
									stat_q <= pts_pkg::STAT_NOT_RUNNING;
								end else if (in_ticks != '0) begin
									sst_q[run_q] <= pts_pkg::SL_BLOCKED;
									wake_q[run_q] <= in_ticks;
								end
							end
							default: ;
						endcase
					end
				end
				// Compare walk: find first entry not above the new priority.
				pts_pkg::ST_INS_FIND: begin
					if (len_q < LW'(MAX_THREADS)) begin
						if (pos_q < len_q
								&& prio_q[order_q[pos_q[SW-1:0]]] > prio_q[ins_slot_q]) begin
							pos_q <= pos_q + LW'(1);
						end else begin
							idx_q <= len_q;
						end
					end
				end
				// Shift walk: move entries up one, then drop in the slot.
				pts_pkg::ST_INS_SHIFT: begin
					if (idx_q > pos_q) begin
						order_q[idx_q[SW-1:0]] <= order_q[idx_q[SW-1:0] - SW'(1)];
						idx_q <= idx_q - LW'(1);
					end else begin
						order_q[pos_q[SW-1:0]] <= ins_slot_q;
						len_q <= len_q + LW'(1);
						sst_q[ins_slot_q] <= pts_pkg::SL_READY;
						if (req_q == pts_pkg::REQ_TICK) begin
							if (woken_q != 5'd31) woken_q <= woken_q + 5'd1;
							tick_i_q <= tick_i_q + SW'(1);
						end
						pos_q <= '0;
						idx_q <= '0;
					end
					if (req_q == pts_pkg::REQ_TICK && len_q >= LW'(MAX_THREADS)) begin
						tick_i_q <= tick_i_q + SW'(1);
					end
				end
				// Pop walk: take the head, then close the gap.
				pts_pkg::ST_POP: begin
					if (len_q == '0) begin
						stat_q <= pts_pkg::STAT_NO_READY;
					end else begin
						if (idx_q == '0) begin
							run_q <= order_q[0];
							run_vld_q <= 1'b1;
							next_q <= 4'(order_q[0]);
							sw_q <= 1'b1;
							sst_q[order_q[0]] <= pts_pkg::SL_RUNNING;
						end
						if (idx_q + LW'(1) < len_q) begin
							order_q[idx_q[SW-1:0]] <= order_q[idx_q[SW-1:0] + SW'(1)];
							idx_q <= idx_q + LW'(1);
						end else begin
							len_q <= len_q - LW'(1);
						end
					end
				end
				// Timer walk: one slot per cycle, paused while a woken slot is inserted.
				pts_pkg::ST_TICK: begin
					if (wake_q[tick_i_q] != '0) begin
						wake_q[tick_i_q] <= wdec;
					end
					if (wake_q[tick_i_q] != '0 && wdec == '0
							&& sst_q[tick_i_q] == pts_pkg::SL_BLOCKED) begin
						if (run_vld_q && run_q == tick_i_q) begin
							sst_q[tick_i_q] <= pts_pkg::SL_RUNNING;
							tick_i_q <= tick_i_q + SW'(1);
						end else begin
							ins_slot_q <= tick_i_q;
							pos_q <= '0;
						end
					end else begin
						tick_i_q <= tick_i_q + SW'(1);
					end
				end
				pts_pkg::ST_DONE: out_vld_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

// ===== tb/tb_priority_thread_scheduler.sv =====
// Testbench for the priority thread scheduler: drives request words, predicts
// every result word from a local scheduler model and compares. Depends on pts_pkg.
`timescale 1ns / 100ps

module tb_priority_thread_scheduler;
	localparam int NSLOT = pts_pkg::MAX_THREADS_DEF;

	// Packed from the top bit down, so status lands in the lowest bits.
	typedef struct packed {
		logic [4:0] woken_count;
		logic switch_now;
		logic [3:0] next_thread;
		logic [3:0] prev_thread;
		logic [3:0] new_thread;
		logic [1:0] status;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;

	// Scheduler state mirrored by the predictor.
	logic [7:0] prio_of [NSLOT];
	pts_pkg::slot_state_t state_of [NSLOT];
	logic [31:0] wake_left [NSLOT];
	int ready_q [$];
	int cur_slot;
	bit cur_valid;
	int free_slot;

	sched_result_t expected_q [$];
	int errors;

	priority_thread_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	task automatic clear_model();
		for (int i = 0; i < NSLOT; i++) begin
			prio_of[i] = '0;
			state_of[i] = pts_pkg::SL_IDLE;
			wake_left[i] = '0;
		end
		state_of[0] = pts_pkg::SL_READY;
		ready_q = '{0};
		cur_slot = 0;
		cur_valid = 0;
		free_slot = 1;
	endtask

	// Sorted insert: a new entry goes ahead of equal priorities.
	function automatic void make_ready(input int slot);
		int pos;
		pos = 0;
		if (ready_q.size() >= NSLOT)
			return;
		while (pos < ready_q.size() && prio_of[ready_q[pos]] > prio_of[slot])
			pos++;
		ready_q.insert(pos, slot);
		state_of[slot] = pts_pkg::SL_READY;
	endfunction

	function automatic sched_result_t predict_request(input pts_pkg::req_t req,
			input logic [7:0] prio, input logic [31:0] ticks);
		sched_result_t r;
		int head;
		r = '0;
		case (req)
			pts_pkg::REQ_CREATE: begin
				if (free_slot >= NSLOT) begin
					r.status = pts_pkg::STAT_FULL;
				end else begin
					prio_of[free_slot] = prio;
					make_ready(free_slot);
					r.new_thread = 4'(free_slot);
					free_slot++;
				end
			end
			pts_pkg::REQ_SCHEDULE: begin
				if (cur_valid) begin
					r.prev_thread = 4'(cur_slot);
					if (state_of[cur_slot] != pts_pkg::SL_BLOCKED)
						make_ready(cur_slot);
					cur_valid = 0;
				end
				if (ready_q.size() == 0) begin
					r.status = pts_pkg::STAT_NO_READY;
				end else begin
					head = ready_q.pop_front();
					state_of[head] = pts_pkg::SL_RUNNING;
					cur_slot = head;
					cur_valid = 1;
					r.next_thread = 4'(head);
					r.switch_now = 1'b1;
				end
			end
			pts_pkg::REQ_SLEEP: begin
				if (!cur_valid) begin
					r.status = pts_pkg::STAT_NOT_RUNNING;
				end else if (ticks != 0) begin
					state_of[cur_slot] = pts_pkg::SL_BLOCKED;
					wake_left[cur_slot] = ticks;
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (wake_left[i] == 0)
						continue;
					wake_left[i]--;
					if (wake_left[i] != 0 || state_of[i] != pts_pkg::SL_BLOCKED)
						continue;
					if (cur_valid && cur_slot == i) begin
						state_of[i] = pts_pkg::SL_RUNNING;
					end else begin
						make_ready(i);
						if (r.woken_count < 31)
							r.woken_count++;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Sends one request word after a random gap and queues its prediction.
	task automatic send_request(input pts_pkg::req_t req, input logic [7:0] prio = 8'd0,
			input logic [31:0] ticks = 32'd0);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(negedge clk);
		s_axis_tdata = {6'd0, ticks, prio, req};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_q.push_back(predict_request(req, prio, ticks));
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	// Result checker with random back-pressure drawn for every word.
	initial begin
		sched_result_t got, exp;
		int hold;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_axis_tready = 1'b0;
			hold = $urandom_range(0, 5);
			repeat (hold) @(negedge clk);
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			got = m_axis_tdata[19:0];
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, got);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (got.status !== exp.status)
					$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				if (got.new_thread !== exp.new_thread)
					$display("%0t: new_thread expected %0d actual %0d", $time,
						exp.new_thread, got.new_thread);
				if (got.prev_thread !== exp.prev_thread)
					$display("%0t: prev_thread expected %0d actual %0d", $time,
						exp.prev_thread, got.prev_thread);
				if (got.next_thread !== exp.next_thread)
					$display("%0t: next_thread expected %0d actual %0d", $time,
						exp.next_thread, got.next_thread);
				if (got.switch_now !== exp.switch_now)
					$display("%0t: switch_now expected %0d actual %0d", $time,
						exp.switch_now, got.switch_now);
				if (got.woken_count !== exp.woken_count)
					$display("%0t: woken_count expected %0d actual %0d", $time,
						exp.woken_count, got.woken_count);
				if (got !== exp || m_axis_tdata[23:20] !== 4'd0)
					errors++;
			end
			@(negedge clk);
		end
	end

	// Idle thread only: nothing running, no ready thread after it sleeps.
	task automatic test_idle_cases();
		send_request(pts_pkg::REQ_SLEEP, 8'd0, 32'd5);
		send_request(pts_pkg::REQ_TICK);
		send_request(pts_pkg::REQ_SCHEDULE);
		send_request(pts_pkg::REQ_SLEEP, 8'd0, 32'd0);
		send_request(pts_pkg::REQ_SLEEP, 8'd0, 32'hFFFF_FFFF);
		send_request(pts_pkg::REQ_SLEEP, 8'd0, 32'd2);
		send_request(pts_pkg::REQ_SCHEDULE);
		send_request(pts_pkg::REQ_SCHEDULE);
		send_request(pts_pkg::REQ_TICK);
		send_request(pts_pkg::REQ_TICK);
		send_request(pts_pkg::REQ_SCHEDULE);
	endtask

	// Equal priorities, extremes, running thread waking in place, full table.
	task automatic test_table_fill();
		send_request(pts_pkg::REQ_CREATE, 8'd255);
		send_request(pts_pkg::REQ_CREATE, 8'd0);
		send_request(pts_pkg::REQ_CREATE, 8'd255);
		send_request(pts_pkg::REQ_SCHEDULE);
		send_request(pts_pkg::REQ_SLEEP, 8'd0, 32'd1);
		send_request(pts_pkg::REQ_TICK);
		send_request(pts_pkg::REQ_SCHEDULE);
		for (int i = 0; i < 12; i++)
			send_request(pts_pkg::REQ_CREATE, 8'($urandom_range(0, 255)));
		send_request(pts_pkg::REQ_CREATE, 8'hAA);
	endtask

	// Mostly well-formed sleep/tick/schedule cycles, with some creates, over the table left by test_table_fill.
	task automatic test_random_traffic(input int count);
		int pick;
		logic [31:0] t;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			t = ($urandom_range(0, 19) == 0) ? $urandom() : 32'($urandom_range(0, 6));
			if (pick < 8)
				send_request(pts_pkg::REQ_CREATE, 8'($urandom()));
			else if (pick < 40)
				send_request(pts_pkg::REQ_SCHEDULE);
			else if (pick < 60)
				send_request(pts_pkg::REQ_SLEEP, 8'($urandom()), t);
			else
				send_request(pts_pkg::REQ_TICK, 8'($urandom()), $urandom());
			if (n == count / 2)
				wait_drained();
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		clear_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_cases();
		test_table_fill();
		test_random_traffic(1320);
		wait_drained();
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
